// ----- src/cdq_pkg.sv -----
// Shared constants, types and index helpers for the circular deque.
`default_nettype none
package cdq_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CAP_W = IDX_W + 1;
	localparam int VAL_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	localparam logic [1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic take;
		logic exec;
		logic load_out;
	} cdq_cmd_t;

	typedef struct packed {
		logic out_busy;
	} cdq_stat_t;

	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] r;
		if (cap == '0) begin
			r = CAP_W'(1);
		end else if (cap > CAP_W'(DEPTH)) begin
			r = CAP_W'(DEPTH);
		end else begin
			r = cap;
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] nxt;
		nxt = {1'b0, i} + CAP_W'(1);
		return (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] last;
		last = cap - CAP_W'(1);
		return (i == '0) ? last[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

endpackage
`default_nettype wire

// ----- src/circular_deque_core.sv -----
// Top level of the circular deque: sequencer plus datapath.
`default_nettype none
// A double-ended queue of 32-bit words in a 64-entry memory. Each input word
// carries one operation (push back, push front, pop front, pop back); each
// yields one result word with the popped value (zero unless a pop succeeds)
// and a status: done, pop refused because empty, or push refused because
// full. The capacity register (reset 64, zero reads as 1, above 64 as 64)
// sets how many entries count as full; write it only while the block is idle.
// An operation runs as capture, execute (index update and one memory
// access), then result load. No new word is taken until the result is
// loaded, and the load waits while the output side stalls. The memory's
// registered read port makes the result load a step of its own. A finished
// result waits in the output register while the next word is taken in.
module circular_deque_core import cdq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       op,
	input  wire logic [VAL_W-1:0] push_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [VAL_W-1:0]      pop_value,
	output logic [1:0]            status,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	cdq_cmd_t  cmd;
	cdq_stat_t dp_stat;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	cdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_stat    (dp_stat),
		.op         (op),
		.push_value (push_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pop_value  (pop_value),
		.status     (status)
	);

	a_take_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in flight");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |-> ##3 out_valid)
		else $error("result missing three cycles after a word was taken");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_DONE) |-> (pop_value == '0))
		else $error("refused operation returned a nonzero value");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.exec, cmd.load_out}))
		else $error("sequencer issued overlapping commands");

endmodule
`default_nettype wire

// ----- src/cdq_ctrl.sv -----
// Sequencer for the deque: take a word, execute it, hand the result over.
`default_nettype none
module cdq_ctrl import cdq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire cdq_stat_t dp_stat,
	output cdq_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				// hold until the output register can take the word
				if (!dp_stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/cdq_dp.sv -----
// Deque datapath: indices, empty flag, entry memory and output register.
`default_nettype none
module cdq_dp import cdq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cdq_cmd_t         cmd,
	output cdq_stat_t             dp_stat,
	input  wire logic [1:0]       op,
	input  wire logic [VAL_W-1:0] push_value,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [VAL_W-1:0]      pop_value,
	output logic [1:0]            status
);

	logic [VAL_W-1:0] mem [DEPTH];

	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic             empty_q;
	logic             out_valid_q;

	logic [1:0]       op_q;
	logic [VAL_W-1:0] val_q;
	logic             pop_ok_q;
	logic [1:0]       res_stat_q;
	logic [VAL_W-1:0] rd_data_q;
	logic [VAL_W-1:0] pop_value_q;
	logic [1:0]       status_q;

	logic [CAP_W-1:0] cap;
	logic [IDX_W-1:0] head_d, tail_d, waddr, raddr;
	logic             empty_d, mem_we, mem_re, pop_ok_d;
	logic [1:0]       res_stat_d;
	logic             is_push, full;

	assign cap     = eff_cap(cap_q);
	assign is_push = (op_q == OP_PUSH_BACK) || (op_q == OP_PUSH_FRONT);
	assign full    = (step_fwd(tail_q, cap) == head_q);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		waddr      = '0;
		raddr      = head_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		pop_ok_d   = 1'b0;
		res_stat_d = STAT_DONE;
		if (is_push) begin
			if (empty_q) begin
				// restart both ends at slot zero
				head_d  = '0;
				tail_d  = '0;
				empty_d = 1'b0;
				mem_we  = 1'b1;
			end else if (full) begin
				res_stat_d = STAT_FULL;
			end else if (op_q == OP_PUSH_BACK) begin
				tail_d = step_fwd(tail_q, cap);
				waddr  = tail_d;
				mem_we = 1'b1;
			end else begin
				head_d = step_back(head_q, cap);
				waddr  = head_d;
				mem_we = 1'b1;
			end
		end else begin
			if (empty_q) begin
				res_stat_d = STAT_EMPTY;
			end else if (head_q == tail_q) begin
				// last entry leaves: keep the indices
				mem_re   = 1'b1;
				pop_ok_d = 1'b1;
				empty_d  = 1'b1;
			end else if (op_q == OP_POP_FRONT) begin
				mem_re   = 1'b1;
				pop_ok_d = 1'b1;
				head_d   = step_fwd(head_q, cap);
			end else begin
				raddr    = tail_q;
				mem_re   = 1'b1;
				pop_ok_d = 1'b1;
				tail_d   = step_back(tail_q, cap);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				empty_q <= empty_d;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op;
			val_q <= push_value;
		end
		if (cmd.exec) begin
			pop_ok_q   <= pop_ok_d;
			res_stat_q <= res_stat_d;
		end
		if (cmd.load_out) begin
			pop_value_q <= pop_ok_q ? rd_data_q : '0;
			status_q    <= res_stat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[waddr] <= val_q;
		end
		if (cmd.exec && mem_re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign dp_stat.out_busy = out_valid_q && out_stall;
	assign out_valid        = out_valid_q;
	assign pop_value        = pop_value_q;
	assign status           = status_q;

endmodule
`default_nettype wire
